[design/ght_pkg.sv]
// Shared codes and field widths for the generational handle table.
`default_nettype none
package ght_pkg;

  // field widths of the transfer payloads
  localparam int OP_W        = 3;
  localparam int IDX_IN_W    = 16;
  localparam int HGEN_W      = 16;
  localparam int STATUS_W    = 3;
  localparam int OUT_SLOT_W  = 4;
  localparam int OUT_GEN_W   = 16;
  localparam int COUNT_W     = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_INIT     = 3'd0;
  localparam logic [OP_W-1:0] OP_SHUTDOWN = 3'd1;
  localparam logic [OP_W-1:0] OP_CREATE   = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE   = 3'd3;
  localparam logic [OP_W-1:0] OP_DESTROY  = 3'd4;
  localparam logic [OP_W-1:0] OP_VALIDATE = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STALE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_MATRIX = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_INIT   = 3'd4;

endpackage
`default_nettype wire

[design/ght_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ght_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[design/ght_gen_unit.sv]
// Shared generation unit: handle compare and wrap-safe generation bump.
`default_nettype none
module ght_gen_unit #(
  parameter int GEN_BITS = 16
) (
  input  logic [GEN_BITS-1:0]       gen_rd,
  input  logic                      gen_live,
  input  logic [ght_pkg::HGEN_W-1:0] handle_generation,
  output logic                      gen_match,
  output logic [GEN_BITS-1:0]       gen_bumped
);

  logic [GEN_BITS-1:0] gen_cur;
  logic [GEN_BITS-1:0] gen_inc;

  // an entry never written since the last clear reads as generation zero
  assign gen_cur = gen_live ? gen_rd : '0;
  assign gen_inc = gen_cur + GEN_BITS'(1);
  // skip zero on wrap
  assign gen_bumped = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
  assign gen_match  = (32'(gen_cur) == 32'(handle_generation));

endmodule
`default_nettype wire

[design/generational_handle_table.sv]
// Top level of the generational handle table: sequencer, slot state and result register.
//
// Usage: one request channel (in_valid / in_stall) carries op, slot_index,
// handle_generation, matrix_ok and storage_ok; one result channel
// (out_valid / out_stall) carries ok, status, out_slot, out_generation,
// active_count and peak_count. Every request gives exactly one result.
// A transfer happens on a rising edge with valid high and stall low.
// Steps, from request transfer to result valid:
//   init, shutdown, unused codes and early rejects: decode step only
//   update, destroy, validate: decode, one generation read, then check
//   create: decode, scan, bump, where the scan stops at the lowest free slot;
//   the sequencer scans the active bits one slot per cycle, so a full
//   table is scanned to its last slot before "no free slot" is reported.
// One request is in flight at a time; in_stall is high while it is worked.
// A new request is taken while the previous result still waits; the next
// result is held in its final step until the output register is free, so
// a stalled receiver holds the block, never drops or repeats a result.
// Reset clears every slot, the ready flag, both counts and the output
// valid flag; generation storage needs no clearing pass (per-slot live bits).
`default_nettype none
module generational_handle_table #(
  parameter int SLOT_COUNT = 16,
  parameter int GEN_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ght_pkg::OP_W-1:0]          op,
  input  logic [ght_pkg::IDX_IN_W-1:0]      slot_index,
  input  logic [ght_pkg::HGEN_W-1:0]        handle_generation,
  input  logic                              matrix_ok,
  input  logic                              storage_ok,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              ok,
  output logic [ght_pkg::STATUS_W-1:0]      status,
  output logic [ght_pkg::OUT_SLOT_W-1:0]    out_slot,
  output logic [ght_pkg::OUT_GEN_W-1:0]     out_generation,
  output logic [ght_pkg::COUNT_W-1:0]       active_count,
  output logic [ght_pkg::COUNT_W-1:0]       peak_count
);
  import ght_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_BUMP   = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;

  // table side effects applied when a result is committed
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_INIT    = 3'd1;
  localparam logic [2:0] ACT_SHUT    = 3'd2;
  localparam logic [2:0] ACT_CREATE  = 3'd3;
  localparam logic [2:0] ACT_DESTROY = 3'd4;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [IDX_W-1:0]      ptr;
  logic [IDX_W-1:0]      ptr_next;

  // latched request
  logic [OP_W-1:0]       op_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  in_range_q;
  logic [HGEN_W-1:0]     hgen_q;
  logic                  mat_q;
  logic                  store_q;

  // table state
  logic [SLOT_COUNT-1:0] slot_active;
  logic [SLOT_COUNT-1:0] gen_live;
  logic                  table_ready;
  logic [CNT_W-1:0]      active_cnt;
  logic [CNT_W-1:0]      peak;

  // sequencer outputs
  logic                  accept;
  logic                  in_range;
  logic                  out_free;
  logic                  fin;
  logic                  commit;
  logic                  res_ok;
  logic [STATUS_W-1:0]   res_status;
  logic [2:0]            act;
  logic [CNT_W-1:0]      cnt_after;
  logic [CNT_W-1:0]      peak_after;

  // generation storage and shared unit
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [GEN_BITS-1:0]   rd_data;
  logic [IDX_W-1:0]      sel_slot;
  logic                  gen_match;
  logic [GEN_BITS-1:0]   gen_bumped;

  // widened copies for truncation onto the result fields
  logic [31:0]           cnt_wide;
  logic [31:0]           peak_wide;
  logic [31:0]           slot_wide;
  logic [31:0]           gen_wide;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign commit   = fin && out_free;
  assign in_range = (32'(slot_index) < 32'(SLOT_COUNT));

  // the slot whose generation is on the read port
  assign sel_slot = (state == S_CHECK) ? idx_q : ptr;

  ght_ram #(
    .WIDTH (GEN_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_gen_ram (
    .clk     (clk),
    .wr_en   (commit && (act == ACT_CREATE)),
    .wr_addr (ptr),
    .wr_data (gen_bumped),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ght_gen_unit #(
    .GEN_BITS (GEN_BITS)
  ) u_gen_unit (
    .gen_rd            (rd_data),
    .gen_live          (gen_live[sel_slot]),
    .handle_generation (hgen_q),
    .gen_match         (gen_match),
    .gen_bumped        (gen_bumped)
  );

  // sequencer
  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    fin        = 1'b0;
    res_ok     = 1'b0;
    res_status = ST_OK;
    act        = ACT_NONE;
    rd_en      = 1'b0;
    rd_addr    = ptr;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_q)
          OP_INIT: begin
            fin    = 1'b1;
            res_ok = 1'b1;
            act    = ACT_INIT;
          end
          OP_SHUTDOWN: begin
            fin    = 1'b1;
            res_ok = 1'b1;
            act    = ACT_SHUT;
          end
          OP_CREATE: begin
            if (!table_ready) begin
              fin        = 1'b1;
              res_status = ST_NOT_INIT;
            end else if (!mat_q) begin
              fin        = 1'b1;
              res_status = ST_BAD_MATRIX;
            end else if (!store_q) begin
              fin        = 1'b1;
              res_status = ST_NO_SLOT;
            end else begin
              ptr_next   = '0;
              state_next = S_SCAN;
            end
          end
          OP_UPDATE, OP_DESTROY, OP_VALIDATE: begin
            if (!table_ready) begin
              fin        = 1'b1;
              res_status = ST_NOT_INIT;
            end else if (!in_range_q) begin
              fin        = 1'b1;
              res_status = ST_STALE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = idx_q;
              state_next = S_CHECK;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        if (!slot_active[ptr]) begin
          rd_en      = 1'b1;
          state_next = S_BUMP;
        end else if (ptr == LAST_SLOT) begin
          fin        = 1'b1;
          res_status = ST_NO_SLOT;
        end else begin
          ptr_next = ptr + IDX_W'(1);
        end
      end
      S_BUMP: begin
        fin    = 1'b1;
        res_ok = 1'b1;
        act    = ACT_CREATE;
      end
      S_CHECK: begin
        fin = 1'b1;
        if (!(slot_active[idx_q] && gen_match)) begin
          res_status = ST_STALE;
        end else if ((op_q == OP_UPDATE) && !mat_q) begin
          res_status = ST_BAD_MATRIX;
        end else begin
          res_ok = 1'b1;
          if (op_q == OP_DESTROY) begin
            act = ACT_DESTROY;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // hold the final step until the output register can take the result
    if (fin) begin
      state_next = commit ? S_IDLE : state;
    end
  end

  // counts after the operation
  always_comb begin
    cnt_after  = active_cnt;
    peak_after = peak;
    case (act)
      ACT_INIT: begin
        cnt_after  = '0;
        peak_after = '0;
      end
      ACT_SHUT: begin
        cnt_after = '0;
      end
      ACT_CREATE: begin
        cnt_after = active_cnt + CNT_W'(1);
        if (cnt_after > peak) begin
          peak_after = cnt_after;
        end
      end
      ACT_DESTROY: begin
        cnt_after = active_cnt - CNT_W'(1);
      end
      default: begin
        cnt_after = active_cnt;
      end
    endcase
  end

  assign cnt_wide  = 32'(cnt_after);
  assign peak_wide = 32'(peak_after);
  assign slot_wide = 32'(ptr);
  assign gen_wide  = 32'(gen_bumped);

  // control state and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ptr         <= '0;
      out_valid   <= 1'b0;
      slot_active <= '0;
      gen_live    <= '0;
      table_ready <= 1'b0;
      active_cnt  <= '0;
      peak        <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      // load a new result, or drop the old one once it has been taken
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (commit) begin
        active_cnt <= cnt_after;
        peak       <= peak_after;
        case (act)
          ACT_INIT: begin
            slot_active <= '0;
            gen_live    <= '0;
            table_ready <= 1'b1;
          end
          ACT_SHUT: begin
            slot_active <= '0;
            gen_live    <= '0;
            table_ready <= 1'b0;
          end
          ACT_CREATE: begin
            slot_active[ptr] <= 1'b1;
            gen_live[ptr]    <= 1'b1;
          end
          ACT_DESTROY: begin
            slot_active[idx_q] <= 1'b0;
          end
          default: begin
            table_ready <= table_ready;
          end
        endcase
      end
    end
  end

  // request latch and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= op;
      idx_q      <= slot_index[IDX_W-1:0];
      in_range_q <= in_range;
      hgen_q     <= handle_generation;
      mat_q      <= matrix_ok;
      store_q    <= storage_ok;
    end
    if (commit) begin
      ok           <= res_ok;
      status       <= res_status;
      active_count <= cnt_wide[COUNT_W-1:0];
      peak_count   <= peak_wide[COUNT_W-1:0];
      if (act == ACT_CREATE) begin
        out_slot       <= slot_wide[OUT_SLOT_W-1:0];
        out_generation <= gen_wide[OUT_GEN_W-1:0];
      end else begin
        out_slot       <= '0;
        out_generation <= '0;
      end
    end
  end

  // running count tracks the active bits
  a_count_matches : assert property (@(posedge clk) disable iff (rst)
    $countones(slot_active) == 32'(active_cnt))
    else $error("active count out of step with active bits");

  // peak never falls below the current count
  a_peak_covers : assert property (@(posedge clk) disable iff (rst)
    peak >= active_cnt)
    else $error("peak count below active count");

  // a committed create leaves its slot active
  a_create_marks : assert property (@(posedge clk) disable iff (rst)
    (state == S_BUMP) && commit |=> slot_active[ptr] && gen_live[ptr])
    else $error("created slot not marked active");

  // the free-slot scan only runs on a ready table
  a_scan_ready : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) || (state == S_BUMP) |-> table_ready)
    else $error("slot scan on a table that is not ready");

endmodule
`default_nettype wire
